[rtl/assert_macros.svh]
// assertion helpers for the codebook background model
// no dependencies; included by modules that carry checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CBM_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define CBM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CBM_ASSERT(lbl, clk, rstn, prop, msg)
`define CBM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[rtl/cbm_pkg.sv]
// shared types and constants of the codebook background model
// no dependencies
`default_nettype none
package cbm_pkg;
    localparam int NUM_PIXELS  = 1024;
    localparam int MAX_ENTRIES = 8;
    localparam int TIME_BITS   = 16;
    localparam int PIX_W       = 10;
    localparam int SLOT_W      = 3;
    localparam int CNT_W       = 4;
    localparam int CH_W        = 8;
    localparam int BOX_W       = 24;
    localparam int MOD_W       = 9;

    typedef enum logic [1:0] {
        REQ_LEARN    = 2'd0,
        REQ_PRUNE    = 2'd1,
        REQ_CLASSIFY = 2'd2,
        REQ_NONE     = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        CFG_BOUNDS  = 3'd0,
        CFG_MIN_Y   = 3'd1,
        CFG_MIN_U   = 3'd2,
        CFG_MIN_V   = 3'd3,
        CFG_MAX_Y   = 3'd4,
        CFG_MAX_U   = 3'd5,
        CFG_MAX_V   = 3'd6,
        CFG_UNUSED  = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PIX,
        S_WALK,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [BOX_W-1:0]     lhigh;
        logic [BOX_W-1:0]     llow;
        logic [BOX_W-1:0]     smax;
        logic [BOX_W-1:0]     smin;
        logic [TIME_BITS-1:0] touch;
        logic [TIME_BITS-1:0] idle;
    } t_entry;

    typedef struct packed {
        logic [CNT_W-1:0]     cnt;
        logic [TIME_BITS-1:0] ltime;
    } t_pix_word;

    typedef struct packed {
        t_req                 mode;
        logic                 found;
        logic [TIME_BITS-1:0] t;
        logic [TIME_BITS-1:0] thresh;
    } t_eu_ctrl;

    typedef struct packed {
        logic in_box;
        logic bg_match;
        logic keep;
    } t_eu_res;

    localparam logic [TIME_BITS-1:0] TIME_LIMIT = {TIME_BITS{1'b1}};
endpackage
`default_nettype wire

[rtl/cbm_if.sv]
// handshake channels of the codebook background model
// depends on cbm_pkg
`default_nettype none
interface cbm_in_if;
    import cbm_pkg::*;
    logic             valid;
    logic             ready;
    logic [1:0]       req_type;
    logic [PIX_W-1:0] pixel_index;
    logic [CH_W-1:0]  pixel_y;
    logic [CH_W-1:0]  pixel_u;
    logic [CH_W-1:0]  pixel_v;
    modport source (output valid, req_type, pixel_index, pixel_y, pixel_u, pixel_v,
                    input ready);
    modport sink (input valid, req_type, pixel_index, pixel_y, pixel_u, pixel_v,
                  output ready);
endinterface

interface cbm_out_if;
    import cbm_pkg::*;
    logic             valid;
    logic             ready;
    logic             foreground;
    logic [CNT_W-1:0] entry_count;
    logic [CNT_W-1:0] cleared_count;
    logic             book_full;
    modport source (output valid, foreground, entry_count, cleared_count, book_full,
                    input ready);
    modport sink (input valid, foreground, entry_count, cleared_count, book_full,
                  output ready);
endinterface

interface cbm_cfg_if;
    import cbm_pkg::*;
    logic             valid;
    logic             ready;
    logic [2:0]       index;
    logic [BOX_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/cbm_ram.sv]
// simple dual port ram, one write and one registered read per cycle
// no dependencies
`default_nettype none
module cbm_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 20
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[rtl/cbm_entry_unit.sv]
// shared per-entry unit: box tests, entry update, idle run and prune test
// depends on cbm_pkg
`default_nettype none
module cbm_entry_unit (
    input  wire cbm_pkg::t_eu_ctrl                 i_ctrl,
    input  wire cbm_pkg::t_entry                   i_entry,
    input  wire logic [cbm_pkg::BOX_W-1:0]         i_pix,
    input  wire logic [cbm_pkg::BOX_W-1:0]         i_bounds,
    input  wire logic signed [cbm_pkg::MOD_W-1:0]  i_lm [3],
    input  wire logic signed [cbm_pkg::MOD_W-1:0]  i_hm [3],
    output cbm_pkg::t_entry                        o_entry,
    output logic [cbm_pkg::BOX_W-1:0]              o_hi,
    output logic [cbm_pkg::BOX_W-1:0]              o_lo,
    output cbm_pkg::t_eu_res                       o_res
);
    import cbm_pkg::*;

    logic [CH_W:0]          sum;
    logic [CH_W-1:0]        p, b, h, l;
    logic signed [CH_W+2:0] lo_m, hi_m, ps;
    logic                   box_ok, match_ok;
    logic [TIME_BITS-1:0]   run;

    always_comb begin
        o_entry  = i_entry;
        box_ok   = 1'b1;
        match_ok = 1'b1;
        o_hi     = '0;
        o_lo     = '0;
        for (int c = 0; c < 3; c++) begin
            p = i_pix[CH_W*c +: CH_W];
            b = i_bounds[CH_W*c +: CH_W];
            sum = {1'b0, p} + {1'b0, b};
            o_hi[CH_W*c +: CH_W] = sum[CH_W] ? {CH_W{1'b1}} : sum[CH_W-1:0];
            o_lo[CH_W*c +: CH_W] = (p > b) ? p - b : '0;
            h = i_entry.lhigh[CH_W*c +: CH_W];
            l = i_entry.llow[CH_W*c +: CH_W];
            if (!(l <= p && p <= h)) begin
                box_ok = 1'b0;
            end
            ps   = $signed({3'b000, p});
            lo_m = $signed({3'b000, i_entry.smin[CH_W*c +: CH_W]})
                   - (CH_W+3)'(i_lm[c]);
            hi_m = $signed({3'b000, i_entry.smax[CH_W*c +: CH_W]})
                   + (CH_W+3)'(i_hm[c]);
            if (!(lo_m <= ps && ps <= hi_m)) begin
                match_ok = 1'b0;
            end
        end
        run = (i_ctrl.t >= i_entry.touch) ? i_ctrl.t - i_entry.touch : '0;
        o_res.in_box   = box_ok;
        o_res.bg_match = match_ok;
        o_res.keep     = !(i_entry.idle > i_ctrl.thresh);
        if (i_ctrl.mode == REQ_PRUNE) begin
            o_entry.touch = '0;
        end else if (box_ok && !i_ctrl.found) begin
            // matched entry: touched now, so its idle run cannot grow
            o_entry.touch = i_ctrl.t;
            for (int c = 0; c < 3; c++) begin
                p = i_pix[CH_W*c +: CH_W];
                h = i_entry.lhigh[CH_W*c +: CH_W];
                l = i_entry.llow[CH_W*c +: CH_W];
                if (i_entry.smax[CH_W*c +: CH_W] < p) begin
                    o_entry.smax[CH_W*c +: CH_W] = p;
                end else if (i_entry.smin[CH_W*c +: CH_W] > p) begin
                    o_entry.smin[CH_W*c +: CH_W] = p;
                end
                if (h < o_hi[CH_W*c +: CH_W]) begin
                    o_entry.lhigh[CH_W*c +: CH_W] = h + 1'b1;
                end
                if (l > o_lo[CH_W*c +: CH_W]) begin
                    o_entry.llow[CH_W*c +: CH_W] = l - 1'b1;
                end
            end
        end else if (i_entry.idle < run) begin
            o_entry.idle = run;
        end
    end
endmodule
`default_nettype wire

[rtl/codebook_background_model_top.sv]
// top level of the codebook background model: sequencer, config, stores
// depends on cbm_pkg, cbm_if, cbm_ram, cbm_entry_unit, assert_macros.svh
//
// i_pix_ch carries one beat per request: learn, prune or classify on one
// pixel's codebook. o_res_ch returns exactly one beat per request.
// i_cfg_ch writes the margin registers by index and is always ready; the
// user must see that it is written only while no request is in flight,
// which the block itself does not enforce. Each request passes from
// accept through S_PIX, then S_WALK once per entry in the pixel's book
// (0..8), then S_FIN, where the result is registered; a single entry
// unit visits the stored entries one per cycle from a one-write/one-read
// entry ram. Empty books and unused request codes skip S_WALK. The next
// request can be taken in the same cycle as the result appears.
// After reset the per-pixel count/time ram is swept to zero, one pixel a
// cycle over all 1024 pixels, during which i_pix_ch.ready stays low.
// The result is held in an output register; if the receiver stalls the
// block still takes the next request, walks it, and then waits with its
// result until the held beat is taken.
`default_nettype none
`include "assert_macros.svh"
module codebook_background_model_top (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cbm_in_if.sink    i_pix_ch,
    cbm_out_if.source o_res_ch,
    cbm_cfg_if.sink   i_cfg_ch
);
    import cbm_pkg::*;

    localparam int ENT_DEPTH = NUM_PIXELS * MAX_ENTRIES;

    t_state                   r_state, n_state;
    logic [PIX_W-1:0]         r_clr;
    t_req                     r_req;
    logic [PIX_W-1:0]         r_pix;
    logic [BOX_W-1:0]         r_p;
    logic [CNT_W-1:0]         r_n;
    logic [TIME_BITS-1:0]     r_t;
    logic [TIME_BITS-1:0]     r_thresh;
    logic [SLOT_W-1:0]        r_idx;
    logic [CNT_W-1:0]         r_k;
    logic                     r_found;
    logic [BOX_W-1:0]         r_bounds;
    logic signed [MOD_W-1:0]  r_lm [3];
    logic signed [MOD_W-1:0]  r_hm [3];
    logic                     r_ovalid;
    logic                     r_ofg;
    logic [CNT_W-1:0]         r_ocnt;
    logic [CNT_W-1:0]         r_oclr;
    logic                     r_ofull;

    t_pix_word                pix_rd, pix_wd;
    logic                     pix_we;
    logic [PIX_W-1:0]         pix_wa, pix_ra;
    t_entry                   ent_rd, ent_wd, eu_entry;
    logic                     ent_we;
    logic [PIX_W+SLOT_W-1:0]  ent_wa, ent_ra;
    t_eu_ctrl                 eu_ctrl;
    t_eu_res                  eu_res;
    logic [BOX_W-1:0]         eu_hi, eu_lo;
    logic [CNT_W-1:0]         cnt_rd;
    logic [TIME_BITS-1:0]     t_base;
    logic                     last, fin_go, do_append;

    cbm_ram #(.DEPTH(NUM_PIXELS), .WIDTH($bits(t_pix_word))) u_pix_ram (
        .i_clk   (i_clk),
        .i_we    (pix_we),
        .i_waddr (pix_wa),
        .i_wdata (pix_wd),
        .i_raddr (pix_ra),
        .o_rdata (pix_rd)
    );

    cbm_ram #(.DEPTH(ENT_DEPTH), .WIDTH($bits(t_entry))) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_wa),
        .i_wdata (ent_wd),
        .i_raddr (ent_ra),
        .o_rdata (ent_rd)
    );

    cbm_entry_unit u_eu (
        .i_ctrl   (eu_ctrl),
        .i_entry  (ent_rd),
        .i_pix    (r_p),
        .i_bounds (r_bounds),
        .i_lm     (r_lm),
        .i_hm     (r_hm),
        .o_entry  (eu_entry),
        .o_hi     (eu_hi),
        .o_lo     (eu_lo),
        .o_res    (eu_res)
    );

    assign i_cfg_ch.ready = 1'b1;
    assign i_pix_ch.ready = (r_state == S_IDLE);

    assign o_res_ch.valid         = r_ovalid;
    assign o_res_ch.foreground    = r_ofg;
    assign o_res_ch.entry_count   = r_ocnt;
    assign o_res_ch.cleared_count = r_oclr;
    assign o_res_ch.book_full     = r_ofull;

    assign eu_ctrl.mode   = r_req;
    assign eu_ctrl.found  = r_found;
    assign eu_ctrl.t      = r_t;
    assign eu_ctrl.thresh = r_thresh;

    // stored count above the book size is clamped
    assign cnt_rd = (pix_rd.cnt > CNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : pix_rd.cnt;
    assign t_base = (cnt_rd == '0) ? '0 : pix_rd.ltime;
    assign last   = ({1'b0, r_idx} == r_n - 1'b1);
    assign fin_go = (r_state == S_FIN) && (!r_ovalid || o_res_ch.ready);
    assign do_append = (r_req == REQ_LEARN) && !r_found && (r_n < CNT_W'(MAX_ENTRIES));

    always_comb begin
        n_state = r_state;
        pix_ra  = i_pix_ch.pixel_index;
        pix_we  = 1'b0;
        pix_wa  = r_pix;
        pix_wd  = '{cnt: r_n, ltime: r_t};
        ent_ra  = {r_pix, SLOT_W'(0)};
        ent_we  = 1'b0;
        ent_wa  = {r_pix, r_idx};
        ent_wd  = eu_entry;
        case (r_state)
            S_CLEAR: begin
                pix_we = 1'b1;
                pix_wa = r_clr;
                pix_wd = '0;
                if (r_clr == PIX_W'(NUM_PIXELS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_pix_ch.valid) begin
                    n_state = S_PIX;
                end
            end
            S_PIX: begin
                if (cnt_rd == '0 || r_req == REQ_NONE) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                ent_ra = {r_pix, r_idx + 1'b1};
                if (r_req == REQ_LEARN) begin
                    ent_we = 1'b1;
                end else if (r_req == REQ_PRUNE) begin
                    ent_we = eu_res.keep;
                    ent_wa = {r_pix, r_k[SLOT_W-1:0]};
                end
                if (last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                ent_wa = {r_pix, r_n[SLOT_W-1:0]};
                ent_wd = '{lhigh: eu_hi, llow: eu_lo, smax: r_p, smin: r_p,
                           touch: r_t, idle: '0};
                if (fin_go) begin
                    n_state = S_IDLE;
                    ent_we  = do_append;
                    if (r_req == REQ_LEARN) begin
                        pix_we = 1'b1;
                        pix_wd = '{cnt: r_n + CNT_W'(do_append), ltime: r_t};
                    end else if (r_req == REQ_PRUNE) begin
                        pix_we = 1'b1;
                        pix_wd = '{cnt: r_k, ltime: r_t};
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr    <= '0;
            r_ovalid <= 1'b0;
            r_bounds <= 24'h0A0A0A;
            r_lm[0]  <= 9'sd6;
            r_lm[1]  <= 9'sd20;
            r_lm[2]  <= 9'sd8;
            r_hm[0]  <= 9'sd70;
            r_hm[1]  <= 9'sd20;
            r_hm[2]  <= 9'sd6;
        end else begin
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (o_res_ch.ready) begin
                r_ovalid <= 1'b0;
            end
            if (fin_go) begin
                r_ovalid <= 1'b1;
            end
            if (i_cfg_ch.valid) begin
                case (t_cfg_idx'(i_cfg_ch.index))
                    CFG_BOUNDS: r_bounds <= i_cfg_ch.data;
                    CFG_MIN_Y:  r_lm[0]  <= i_cfg_ch.data[MOD_W-1:0];
                    CFG_MIN_U:  r_lm[1]  <= i_cfg_ch.data[MOD_W-1:0];
                    CFG_MIN_V:  r_lm[2]  <= i_cfg_ch.data[MOD_W-1:0];
                    CFG_MAX_Y:  r_hm[0]  <= i_cfg_ch.data[MOD_W-1:0];
                    CFG_MAX_U:  r_hm[1]  <= i_cfg_ch.data[MOD_W-1:0];
                    CFG_MAX_V:  r_hm[2]  <= i_cfg_ch.data[MOD_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // datapath registers of the request in flight
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_req <= t_req'(i_pix_ch.req_type);
                r_pix <= i_pix_ch.pixel_index;
                r_p   <= {i_pix_ch.pixel_v, i_pix_ch.pixel_u, i_pix_ch.pixel_y};
            end
            S_PIX: begin
                r_n      <= cnt_rd;
                r_idx    <= '0;
                r_k      <= '0;
                r_found  <= 1'b0;
                r_thresh <= pix_rd.ltime >> 1;
                if (r_req == REQ_LEARN) begin
                    r_t <= (t_base < TIME_LIMIT) ? t_base + 1'b1 : t_base;
                end else begin
                    r_t <= pix_rd.ltime;
                end
            end
            S_WALK: begin
                r_idx <= r_idx + 1'b1;
                if (r_req == REQ_LEARN && eu_res.in_box) begin
                    r_found <= 1'b1;
                end
                if (r_req == REQ_CLASSIFY && eu_res.bg_match) begin
                    r_found <= 1'b1;
                end
                if (r_req == REQ_PRUNE && eu_res.keep) begin
                    r_k <= r_k + 1'b1;
                end
            end
            S_FIN: begin
                if (fin_go) begin
                    r_ofg   <= (r_req == REQ_CLASSIFY) && !r_found;
                    r_ofull <= (r_req == REQ_LEARN) && !r_found && !do_append;
                    r_oclr  <= (r_req == REQ_PRUNE) ? r_n - r_k : '0;
                    if (r_req == REQ_PRUNE) begin
                        r_ocnt <= r_k;
                    end else begin
                        r_ocnt <= r_n + CNT_W'(do_append);
                    end
                end
            end
            default: ;
        endcase
    end

    `CBM_ASSERT(a_walk_in_book, i_clk, i_rst_n,
        (r_state == S_WALK) |-> ({1'b0, r_idx} < r_n), "walk index beyond book")
    `CBM_ASSERT(a_result_from_fin, i_clk, i_rst_n,
        $rose(r_ovalid) |-> $past(r_state == S_FIN), "result without finished request")
    `CBM_ASSERT(a_counts_fit, i_clk, i_rst_n,
        r_ovalid |-> (({1'b0, r_ocnt} + {1'b0, r_oclr}) <= (CNT_W+1)'(MAX_ENTRIES)),
        "kept plus cleared exceeds book size")
endmodule
`default_nettype wire
